### rtl/stf_pkg.sv
// ----------------------------------------------------------------------------
// Similarity transform fit package
// Shared types, constants and the solve sequencer program.
// ----------------------------------------------------------------------------
package stf_pkg;

   localparam int MaxPoints     = 128;
   localparam int CountWidth    = $clog2(MaxPoints + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(MaxPoints);
   localparam int CoordWidth    = 24;
   localparam int SumWidth      = 40;
   localparam int MomentWidth   = 64;
   localparam int WideWidth     = 128;
   localparam int CfgWidth      = 13;
   localparam int CoefWidth     = 32;
   localparam int DivCountWidth = 8;
   localparam int ScaleDivBits  = 38;
   localparam int SolveDivBits  = 128;
   localparam int PcWidth       = 6;
   localparam logic [PcWidth-1:0] PcItemEnd = 6'd12;

   localparam logic [1:0] RegCropWidth      = 2'd0;
   localparam logic [1:0] RegCropHeight     = 2'd1;
   localparam logic [1:0] RegTemplateWidth  = 2'd2;
   localparam logic [1:0] RegTemplateHeight = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ZERO_SQ = 2'd1,
      STATUS_ZERO_R  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_LOAD, OP_MAC, OP_STORE, OP_ITEM_END, OP_CHECK_A, OP_CHECK_D, OP_DIV, OP_EMIT
   } op_kind_type;

   typedef enum logic [3:0] {
      SRC_ZERO, SRC_TX, SRC_TY, SRC_DX, SRC_DY, SRC_N, SRC_SQ, SRC_DOT, SRC_CROSS,
      SRC_STX, SRC_STY, SRC_SDX, SRC_SDY
   } src_type;

   typedef enum logic [2:0] {
      DST_SQ, DST_DOT, DST_CROSS, DST_DEN, DST_A, DST_B, DST_C, DST_D
   } dst_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE_MUL, S_SCALE_DIV, S_SCALE_WAIT, S_ACCUM, S_FETCH, S_MAC_WAIT,
      S_DIV_WAIT, S_ROUND, S_SAT, S_EMIT
   } state_type;

   typedef struct packed {
      op_kind_type kind;
      src_type     src_a;
      src_type     src_b;
      logic        neg;
      dst_type     dst;
      logic        shift16;
   } uop_type;

   typedef struct packed {
      logic [CfgWidth-1:0] out_width;
      logic [CfgWidth-1:0] out_height;
      logic [CfgWidth-1:0] template_width;
      logic [CfgWidth-1:0] template_height;
   } cfg_type;

   typedef struct packed {
      logic       latch_item;
      logic       scale_mul;
      logic       scale_axis;
      logic       scale_div;
      logic       scale_store;
      logic       accum;
      logic       mac_load;
      logic       mac_start;
      src_type    src_a;
      src_type    src_b;
      logic       neg;
      logic       store;
      dst_type    dst;
      logic       solve_div;
      logic       shift16;
      logic       round;
      logic       coef_store;
      logic       set_status;
      status_type status;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic mac_busy;
      logic a_zero;
      logic d_zero;
      logic count_full;
      logic last_point;
      logic out_free;
   } stat_type;

   function automatic uop_type mk(op_kind_type kind, src_type a, src_type b, logic neg,
                                  dst_type dst, logic sh);
      uop_type u;
      u.kind    = kind;
      u.src_a   = a;
      u.src_b   = b;
      u.neg     = neg;
      u.dst     = dst;
      u.shift16 = sh;
      return u;
   endfunction

   function automatic uop_type prog_op(input logic [PcWidth-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:  u = mk(OP_LOAD, SRC_SQ, SRC_ZERO, 1'b0, DST_SQ, 1'b0);
         6'd1:  u = mk(OP_MAC, SRC_TX, SRC_TX, 1'b0, DST_SQ, 1'b0);
         6'd2:  u = mk(OP_MAC, SRC_TY, SRC_TY, 1'b0, DST_SQ, 1'b0);
         6'd3:  u = mk(OP_STORE, SRC_ZERO, SRC_ZERO, 1'b0, DST_SQ, 1'b0);
         6'd4:  u = mk(OP_LOAD, SRC_DOT, SRC_ZERO, 1'b0, DST_DOT, 1'b0);
         6'd5:  u = mk(OP_MAC, SRC_TX, SRC_DX, 1'b0, DST_DOT, 1'b0);
         6'd6:  u = mk(OP_MAC, SRC_TY, SRC_DY, 1'b0, DST_DOT, 1'b0);
         6'd7:  u = mk(OP_STORE, SRC_ZERO, SRC_ZERO, 1'b0, DST_DOT, 1'b0);
         6'd8:  u = mk(OP_LOAD, SRC_CROSS, SRC_ZERO, 1'b0, DST_CROSS, 1'b0);
         6'd9:  u = mk(OP_MAC, SRC_DY, SRC_TX, 1'b0, DST_CROSS, 1'b0);
         6'd10: u = mk(OP_MAC, SRC_DX, SRC_TY, 1'b1, DST_CROSS, 1'b0);
         6'd11: u = mk(OP_STORE, SRC_ZERO, SRC_ZERO, 1'b0, DST_CROSS, 1'b0);
         6'd12: u = mk(OP_ITEM_END, SRC_ZERO, SRC_ZERO, 1'b0, DST_SQ, 1'b0);
         6'd13: u = mk(OP_CHECK_A, SRC_ZERO, SRC_ZERO, 1'b0, DST_SQ, 1'b0);
         6'd14: u = mk(OP_LOAD, SRC_ZERO, SRC_ZERO, 1'b0, DST_DEN, 1'b0);
         6'd15: u = mk(OP_MAC, SRC_N, SRC_SQ, 1'b0, DST_DEN, 1'b0);
         6'd16: u = mk(OP_MAC, SRC_STX, SRC_STX, 1'b1, DST_DEN, 1'b0);
         6'd17: u = mk(OP_MAC, SRC_STY, SRC_STY, 1'b1, DST_DEN, 1'b0);
         6'd18: u = mk(OP_STORE, SRC_ZERO, SRC_ZERO, 1'b0, DST_DEN, 1'b0);
         6'd19: u = mk(OP_CHECK_D, SRC_ZERO, SRC_ZERO, 1'b0, DST_DEN, 1'b0);
         6'd20: u = mk(OP_LOAD, SRC_ZERO, SRC_ZERO, 1'b0, DST_A, 1'b0);
         6'd21: u = mk(OP_MAC, SRC_N, SRC_DOT, 1'b0, DST_A, 1'b0);
         6'd22: u = mk(OP_MAC, SRC_STX, SRC_SDX, 1'b1, DST_A, 1'b0);
         6'd23: u = mk(OP_MAC, SRC_STY, SRC_SDY, 1'b1, DST_A, 1'b0);
         6'd24: u = mk(OP_DIV, SRC_ZERO, SRC_ZERO, 1'b0, DST_A, 1'b1);
         6'd25: u = mk(OP_LOAD, SRC_ZERO, SRC_ZERO, 1'b0, DST_B, 1'b0);
         6'd26: u = mk(OP_MAC, SRC_N, SRC_CROSS, 1'b0, DST_B, 1'b0);
         6'd27: u = mk(OP_MAC, SRC_STY, SRC_SDX, 1'b0, DST_B, 1'b0);
         6'd28: u = mk(OP_MAC, SRC_STX, SRC_SDY, 1'b1, DST_B, 1'b0);
         6'd29: u = mk(OP_DIV, SRC_ZERO, SRC_ZERO, 1'b0, DST_B, 1'b1);
         6'd30: u = mk(OP_LOAD, SRC_ZERO, SRC_ZERO, 1'b0, DST_C, 1'b0);
         6'd31: u = mk(OP_MAC, SRC_SQ, SRC_SDX, 1'b0, DST_C, 1'b0);
         6'd32: u = mk(OP_MAC, SRC_STX, SRC_DOT, 1'b1, DST_C, 1'b0);
         6'd33: u = mk(OP_MAC, SRC_STY, SRC_CROSS, 1'b0, DST_C, 1'b0);
         6'd34: u = mk(OP_DIV, SRC_ZERO, SRC_ZERO, 1'b0, DST_C, 1'b0);
         6'd35: u = mk(OP_LOAD, SRC_ZERO, SRC_ZERO, 1'b0, DST_D, 1'b0);
         6'd36: u = mk(OP_MAC, SRC_SQ, SRC_SDY, 1'b0, DST_D, 1'b0);
         6'd37: u = mk(OP_MAC, SRC_STY, SRC_DOT, 1'b1, DST_D, 1'b0);
         6'd38: u = mk(OP_MAC, SRC_STX, SRC_CROSS, 1'b1, DST_D, 1'b0);
         6'd39: u = mk(OP_DIV, SRC_ZERO, SRC_ZERO, 1'b0, DST_D, 1'b0);
         default: u = mk(OP_EMIT, SRC_ZERO, SRC_ZERO, 1'b0, DST_SQ, 1'b0);
      endcase
      return u;
   endfunction

endpackage

### rtl/stf_csr.sv
// ----------------------------------------------------------------------------
// Similarity transform fit configuration registers
// APB-style register file holding the crop and template sizes.
// ----------------------------------------------------------------------------
module stf_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output stf_pkg::cfg_type      cfg
);

   stf_pkg::cfg_type cfg_ff;
   stf_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [stf_pkg::CfgWidth-1:0] wr_val;
   logic [stf_pkg::CfgWidth-1:0] rd_val;

   assign wr_en  = csr_psel && csr_penable && csr_pwrite;
   assign wr_val = csr_pwdata[stf_pkg::CfgWidth-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            stf_pkg::RegCropWidth:      cfg_in.out_width       = wr_val;
            stf_pkg::RegCropHeight:     cfg_in.out_height      = wr_val;
            stf_pkg::RegTemplateWidth:  cfg_in.template_width  = wr_val;
            stf_pkg::RegTemplateHeight: cfg_in.template_height = wr_val;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         stf_pkg::RegCropWidth:      rd_val = cfg_ff.out_width;
         stf_pkg::RegCropHeight:     rd_val = cfg_ff.out_height;
         stf_pkg::RegTemplateWidth:  rd_val = cfg_ff.template_width;
         stf_pkg::RegTemplateHeight: rd_val = cfg_ff.template_height;
         default:                    rd_val = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_width       <= 13'd256;
         cfg_ff.out_height      <= 13'd256;
         cfg_ff.template_width  <= 13'd256;
         cfg_ff.template_height <= 13'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = {{(32 - stf_pkg::CfgWidth){1'b0}}, rd_val};
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

### rtl/stf_mac.sv
// ----------------------------------------------------------------------------
// Similarity transform fit multiply-accumulate unit
// Signed 64 by 64 multiply into a 128-bit accumulator, one 32 by 32 partial
// product per cycle.
// ----------------------------------------------------------------------------
module stf_mac (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  logic [127:0] load_val,
   input  logic         start,
   input  logic [63:0]  op_x,
   input  logic [63:0]  op_y,
   input  logic         neg,
   output logic         busy,
   output logic [127:0] acc
);

   logic [63:0]  xm_ff, ym_ff, xm_in, ym_in;
   logic         sgn_ff, sgn_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  xw, yw;
   logic [127:0] shifted, addend, acc_sum;

   assign xw = step_ff[1] ? xm_ff[63:32] : xm_ff[31:0];
   assign yw = step_ff[0] ? ym_ff[63:32] : ym_ff[31:0];

   always_comb begin
      case (sh_ff)
         2'd0:    shifted = {64'd0, prod_ff};
         2'd1:    shifted = {32'd0, prod_ff, 32'd0};
         2'd2:    shifted = {prod_ff, 64'd0};
         default: shifted = '0;
      endcase
   end

   assign addend  = shifted ^ {128{sgn_ff}};
   assign acc_sum = acc_ff + addend + {127'd0, sgn_ff};

   always_comb begin
      xm_in   = xm_ff;
      ym_in   = ym_ff;
      sgn_in  = sgn_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      prod_in = prod_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      if (load) begin
         acc_in = load_val;
      end
      if (start) begin
         xm_in   = op_x[63] ? (64'd0 - op_x) : op_x;
         ym_in   = op_y[63] ? (64'd0 - op_y) : op_y;
         sgn_in  = op_x[63] ^ op_y[63] ^ neg;
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            prod_in = 64'(xw) * 64'(yw);
            sh_in   = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end
         if (step_ff != 3'd0) begin
            acc_in = acc_sum;
         end
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd4) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      xm_ff   <= xm_in;
      ym_ff   <= ym_in;
      sgn_ff  <= sgn_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;

endmodule

### rtl/stf_div.sv
// ----------------------------------------------------------------------------
// Similarity transform fit divider
// Unsigned restoring divider, one quotient bit per cycle, numerator taken
// from its top bit down for a given number of bits.
// ----------------------------------------------------------------------------
module stf_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [127:0] den,
   input  logic [7:0]   bits,
   output logic         busy,
   output logic [127:0] quot,
   output logic [127:0] rem
);

   logic [127:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in, quot_ff, quot_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [128:0] trial, diff;
   logic         ge;

   assign trial = {rem_ff, num_ff[127]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = bits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[127:0] : trial[127:0];
         quot_in = {quot_ff[126:0], ge};
         num_in  = {num_ff[126:0], 1'b0};
         cnt_in  = cnt_ff - 8'd1;
         if (cnt_ff == 8'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 8'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

### rtl/stf_dp.sv
// ----------------------------------------------------------------------------
// Similarity transform fit datapath
// Item registers, running sums, scaling, solve arithmetic and result register.
// ----------------------------------------------------------------------------
module stf_dp (
   input  logic              clock,
   input  logic              reset,
   input  stf_pkg::cmd_type  cmd,
   output stf_pkg::stat_type stat,
   input  stf_pkg::cfg_type  cfg,
   input  logic [95:0]       req_tdata,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata,
   output logic [1:0]        rsp_tuser
);

   logic signed [23:0] rtx_ff, rty_ff, dx_ff, dy_ff, tx_ff, ty_ff;
   logic               last_ff;
   logic signed [39:0] stx_ff, sty_ff, sdx_ff, sdy_ff;
   logic signed [63:0] sq_ff, dot_ff, cross_ff;
   logic [stf_pkg::CountWidth-1:0] cnt_ff;
   logic [127:0]       den_ff;
   logic               den_neg_ff;
   logic [37:0]        sc_num_ff, sc_num_in;
   logic               sc_neg_ff;
   logic [127:0]       qr_ff;
   logic               sneg_ff;
   logic [31:0]        ca_ff, cb_ff, cc_ff, cd_ff;
   stf_pkg::status_type status_ff;
   logic               valid_ff, valid_in;
   logic [127:0]       data_ff;
   logic [1:0]         user_ff;

   logic [63:0]  opa, opb;
   logic         mac_busy, div_busy;
   logic [127:0] acc, quot, rem;
   logic [127:0] div_num, div_den;
   logic [7:0]   div_bits;
   logic [127:0] sol_shift, sol_mag;
   logic signed [23:0] t_sel;
   logic [23:0]  t_mag;
   logic [12:0]  crop_sel, den_sel, den_eff;
   logic [37:0]  q38;
   logic [23:0]  t_scaled;
   logic         rnd_ge;
   logic [31:0]  lim, mag32, coef;
   logic         out_free;

   function automatic logic [63:0] pick(stf_pkg::src_type s, logic [23:0] tx,
                                        logic [23:0] ty, logic [23:0] dx, logic [23:0] dy,
                                        logic [stf_pkg::CountWidth-1:0] n, logic [63:0] sq,
                                        logic [63:0] dot, logic [63:0] cr, logic [39:0] stx,
                                        logic [39:0] sty, logic [39:0] sdx,
                                        logic [39:0] sdy);
      logic [63:0] v;
      case (s)
         stf_pkg::SRC_TX:    v = {{40{tx[23]}}, tx};
         stf_pkg::SRC_TY:    v = {{40{ty[23]}}, ty};
         stf_pkg::SRC_DX:    v = {{40{dx[23]}}, dx};
         stf_pkg::SRC_DY:    v = {{40{dy[23]}}, dy};
         stf_pkg::SRC_N:     v = {{(64 - stf_pkg::CountWidth){1'b0}}, n};
         stf_pkg::SRC_SQ:    v = sq;
         stf_pkg::SRC_DOT:   v = dot;
         stf_pkg::SRC_CROSS: v = cr;
         stf_pkg::SRC_STX:   v = {{24{stx[39]}}, stx};
         stf_pkg::SRC_STY:   v = {{24{sty[39]}}, sty};
         stf_pkg::SRC_SDX:   v = {{24{sdx[39]}}, sdx};
         stf_pkg::SRC_SDY:   v = {{24{sdy[39]}}, sdy};
         default:            v = '0;
      endcase
      return v;
   endfunction

   assign opa = pick(cmd.src_a, tx_ff, ty_ff, dx_ff, dy_ff, cnt_ff, sq_ff, dot_ff, cross_ff,
                     stx_ff, sty_ff, sdx_ff, sdy_ff);
   assign opb = pick(cmd.src_b, tx_ff, ty_ff, dx_ff, dy_ff, cnt_ff, sq_ff, dot_ff, cross_ff,
                     stx_ff, sty_ff, sdx_ff, sdy_ff);

   stf_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.mac_load),
      .load_val ({{64{opa[63]}}, opa}),
      .start    (cmd.mac_start),
      .op_x     (opa),
      .op_y     (opb),
      .neg      (cmd.neg),
      .busy     (mac_busy),
      .acc      (acc)
   );

   // Scaling: |t| * crop + template / 2, then divided by the template size.
   assign t_sel    = cmd.scale_axis ? rty_ff : rtx_ff;
   assign t_mag    = t_sel[23] ? (24'd0 - t_sel) : t_sel;
   assign crop_sel = cmd.scale_axis ? cfg.out_height : cfg.out_width;
   assign den_sel  = cmd.scale_axis ? cfg.template_height : cfg.template_width;
   assign den_eff  = (den_sel == 13'd0) ? 13'd1 : den_sel;
   assign sc_num_in = 38'(t_mag) * 38'(crop_sel) + 38'(den_eff >> 1);

   assign sol_shift = cmd.shift16 ? (acc << 16) : (acc << 8);
   assign sol_mag   = sol_shift[127] ? (128'd0 - sol_shift) : sol_shift;

   always_comb begin
      if (cmd.solve_div) begin
         div_num  = sol_mag;
         div_den  = den_ff;
         div_bits = 8'(stf_pkg::SolveDivBits);
      end else begin
         div_num  = {sc_num_ff, 90'd0};
         div_den  = {115'd0, den_eff};
         div_bits = 8'(stf_pkg::ScaleDivBits);
      end
   end

   stf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.scale_div | cmd.solve_div),
      .num   (div_num),
      .den   (div_den),
      .bits  (div_bits),
      .busy  (div_busy),
      .quot  (quot),
      .rem   (rem)
   );

   assign q38 = quot[37:0];
   always_comb begin
      if (sc_neg_ff) begin
         t_scaled = (q38 > 38'd8388608) ? 24'h800000 : (24'd0 - q38[23:0]);
      end else begin
         t_scaled = (q38 > 38'd8388607) ? 24'h7FFFFF : q38[23:0];
      end
   end

   assign rnd_ge = {rem, 1'b0} >= {1'b0, den_ff};
   assign lim    = sneg_ff ? 32'h80000000 : 32'h7FFFFFFF;
   assign mag32  = (qr_ff[127:32] != '0) ? lim : ((qr_ff[31:0] > lim) ? lim : qr_ff[31:0]);
   assign coef   = sneg_ff ? (32'd0 - mag32) : mag32;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
      end
   end

   // Running sums and status; cleared by reset and after each result.
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         stx_ff    <= '0;
         sty_ff    <= '0;
         sdx_ff    <= '0;
         sdy_ff    <= '0;
         sq_ff     <= '0;
         dot_ff    <= '0;
         cross_ff  <= '0;
         cnt_ff    <= '0;
         status_ff <= stf_pkg::STATUS_OK;
      end else begin
         if (cmd.accum) begin
            stx_ff <= stx_ff + 40'(tx_ff);
            sty_ff <= sty_ff + 40'(ty_ff);
            sdx_ff <= sdx_ff + 40'(dx_ff);
            sdy_ff <= sdy_ff + 40'(dy_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.store) begin
            case (cmd.dst)
               stf_pkg::DST_SQ:    sq_ff    <= acc[63:0];
               stf_pkg::DST_DOT:   dot_ff   <= acc[63:0];
               stf_pkg::DST_CROSS: cross_ff <= acc[63:0];
               default:            sq_ff    <= sq_ff;
            endcase
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         rtx_ff  <= req_tdata[23:0];
         rty_ff  <= req_tdata[47:24];
         dx_ff   <= req_tdata[71:48];
         dy_ff   <= req_tdata[95:72];
         last_ff <= req_tlast;
      end
      if (cmd.scale_mul) begin
         sc_num_ff <= sc_num_in;
         sc_neg_ff <= t_sel[23];
      end
      if (cmd.scale_store) begin
         if (cmd.scale_axis) begin
            ty_ff <= t_scaled;
         end else begin
            tx_ff <= t_scaled;
         end
      end
      if (cmd.store && cmd.dst == stf_pkg::DST_DEN) begin
         den_ff     <= acc[127] ? (128'd0 - acc) : acc;
         den_neg_ff <= acc[127];
      end
      if (cmd.solve_div) begin
         sneg_ff <= sol_shift[127] ^ den_neg_ff;
      end
      if (cmd.round) begin
         qr_ff <= quot + {127'd0, rnd_ge};
      end
      if (cmd.coef_store) begin
         case (cmd.dst)
            stf_pkg::DST_A: ca_ff <= coef;
            stf_pkg::DST_B: cb_ff <= coef;
            stf_pkg::DST_C: cc_ff <= coef;
            stf_pkg::DST_D: cd_ff <= coef;
            default:        ca_ff <= ca_ff;
         endcase
      end
      if (cmd.emit) begin
         data_ff <= (status_ff == stf_pkg::STATUS_OK) ? {cd_ff, cc_ff, cb_ff, ca_ff} : '0;
         user_ff <= status_ff;
      end
   end

   assign stat.div_busy   = div_busy;
   assign stat.mac_busy   = mac_busy;
   assign stat.a_zero     = (sq_ff == '0);
   assign stat.d_zero     = (den_ff == '0);
   assign stat.count_full = (cnt_ff >= stf_pkg::CountFull);
   assign stat.last_point = last_ff;
   assign stat.out_free   = out_free;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

### rtl/stf_ctrl.sv
// ----------------------------------------------------------------------------
// Similarity transform fit controller
// Sequences scaling, sum updates and the solve program over the datapath.
// ----------------------------------------------------------------------------
module stf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output stf_pkg::cmd_type  cmd,
   input  stf_pkg::stat_type stat
);

   stf_pkg::state_type            state_ff, state_in;
   logic [stf_pkg::PcWidth-1:0]   pc_ff, pc_in;
   logic                          axis_ff, axis_in;
   stf_pkg::uop_type              op;

   assign op = stf_pkg::prog_op(pc_ff);

   always_comb begin
      state_in       = state_ff;
      pc_in          = pc_ff;
      axis_in        = axis_ff;
      cmd            = '0;
      cmd.scale_axis = axis_ff;
      cmd.src_a      = op.src_a;
      cmd.src_b      = op.src_b;
      cmd.neg        = op.neg;
      cmd.dst        = op.dst;
      cmd.shift16    = op.shift16;
      req_tready     = 1'b0;
      case (state_ff)
         stf_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               axis_in        = 1'b0;
               if (stat.count_full) begin
                  pc_in    = stf_pkg::PcItemEnd;
                  state_in = stf_pkg::S_FETCH;
               end else begin
                  state_in = stf_pkg::S_SCALE_MUL;
               end
            end
         end
         stf_pkg::S_SCALE_MUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = stf_pkg::S_SCALE_DIV;
         end
         stf_pkg::S_SCALE_DIV: begin
            cmd.scale_div = 1'b1;
            state_in      = stf_pkg::S_SCALE_WAIT;
         end
         stf_pkg::S_SCALE_WAIT: begin
            if (!stat.div_busy) begin
               cmd.scale_store = 1'b1;
               if (axis_ff) begin
                  state_in = stf_pkg::S_ACCUM;
               end else begin
                  axis_in  = 1'b1;
                  state_in = stf_pkg::S_SCALE_MUL;
               end
            end
         end
         stf_pkg::S_ACCUM: begin
            cmd.accum = 1'b1;
            pc_in     = '0;
            state_in  = stf_pkg::S_FETCH;
         end
         stf_pkg::S_FETCH: begin
            case (op.kind)
               stf_pkg::OP_LOAD: begin
                  cmd.mac_load = 1'b1;
                  pc_in        = pc_ff + 1'b1;
               end
               stf_pkg::OP_MAC: begin
                  cmd.mac_start = 1'b1;
                  state_in      = stf_pkg::S_MAC_WAIT;
               end
               stf_pkg::OP_STORE: begin
                  cmd.store = 1'b1;
                  pc_in     = pc_ff + 1'b1;
               end
               stf_pkg::OP_ITEM_END: begin
                  if (stat.last_point) begin
                     pc_in = pc_ff + 1'b1;
                  end else begin
                     state_in = stf_pkg::S_IDLE;
                  end
               end
               stf_pkg::OP_CHECK_A: begin
                  if (stat.a_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = stf_pkg::STATUS_ZERO_SQ;
                     state_in       = stf_pkg::S_EMIT;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
               stf_pkg::OP_CHECK_D: begin
                  if (stat.d_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = stf_pkg::STATUS_ZERO_R;
                     state_in       = stf_pkg::S_EMIT;
                  end else begin
                     pc_in = pc_ff + 1'b1;
                  end
               end
               stf_pkg::OP_DIV: begin
                  cmd.solve_div = 1'b1;
                  state_in      = stf_pkg::S_DIV_WAIT;
               end
               default: begin
                  state_in = stf_pkg::S_EMIT;
               end
            endcase
         end
         stf_pkg::S_MAC_WAIT: begin
            if (!stat.mac_busy) begin
               pc_in    = pc_ff + 1'b1;
               state_in = stf_pkg::S_FETCH;
            end
         end
         stf_pkg::S_DIV_WAIT: begin
            if (!stat.div_busy) begin
               state_in = stf_pkg::S_ROUND;
            end
         end
         stf_pkg::S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = stf_pkg::S_SAT;
         end
         stf_pkg::S_SAT: begin
            cmd.coef_store = 1'b1;
            pc_in          = pc_ff + 1'b1;
            state_in       = stf_pkg::S_FETCH;
         end
         stf_pkg::S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = stf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stf_pkg::S_IDLE;
         pc_ff    <= '0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

### rtl/similarity_transform_fit_top.sv
// ----------------------------------------------------------------------------
// Similarity transform fit top level
// Least-squares similarity transform over a stream of landmark pairs.
// ----------------------------------------------------------------------------
// The req channel carries one landmark pair per item; tlast marks the last
// pair of a set. The rsp channel carries one result per set: coefficients a, b
// and translations c, d in tdata and the status in tuser. Crop and template
// sizes are to be written over the csr port only while no set is in
// progress; the block itself does not enforce this. One item is taken at a
// time. Each pair scales the template point on each axis by a 38-step
// division and then runs six multiply-accumulates. The last pair adds the
// solve: fifteen multiply-accumulates and four 128-step divisions on the
// shared divider. Pairs beyond the point limit skip the scaling, the sums
// and the multiply-accumulates.
// Reset clears the sums, the point count and the result valid flag and loads
// the size registers with 256. A finished result waits in the output
// register, and the next pair is already taken while it waits; a further
// result holds the block until the receiver takes the one before it.
// ----------------------------------------------------------------------------
module similarity_transform_fit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // template_x, template_y, detected_x, detected_y (24 bits each)
   input  logic [95:0]  req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // scale_cos, scale_sin, shift_x, shift_y (32 bits each)
   output logic [127:0] rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   stf_pkg::cfg_type  cfg;
   stf_pkg::cmd_type  cmd;
   stf_pkg::stat_type stat;

   stf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   stf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   stf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
